FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the encoder's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define VIOE_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: condition violated");

// A condition that must hold in the same cycle as its trigger.
`define VIOE_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication violated");

// A condition that must hold in the cycle after its trigger.
`define VIOE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication violated");

`endif

FILE: hw/rtl/vioe_pkg.sv
// Types, constants and helper functions of the varint offset encoder.
package vioe_pkg;

   localparam int unsigned ValueWidth     = 64;
   localparam int unsigned ByteWidth      = 8;
   localparam int unsigned LenWidth       = 4;
   localparam int unsigned FifoCountWidth = 2;

   localparam logic [LenWidth-1:0]  MaxExtra   = 4'd8;
   localparam logic [ByteWidth-1:0] EscapeByte = 8'hFF;
   localparam logic [FifoCountWidth-1:0] FifoDepth = 2'd2;

   // One classified item waiting for the byte emitter.
   typedef struct packed {
      logic [ValueWidth-1:0] rem;
      logic [LenWidth-1:0]   len;
      logic [ByteWidth-1:0]  head;
   } vioe_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } vioe_fifo_status_type;

   // Upper bound (exclusive) of the values that take k extra bytes.
   function automatic logic [ValueWidth-1:0] limit_of(input logic [2:0] k);
      logic [ValueWidth-1:0] lim;
      case (k)
         3'd0:    lim = 64'h0000_0000_0000_0020;
         3'd1:    lim = 64'h0000_0000_0000_2020;
         3'd2:    lim = 64'h0000_0000_0020_2020;
         3'd3:    lim = 64'h0000_0000_2020_2020;
         3'd4:    lim = 64'h0000_0020_2020_2020;
         3'd5:    lim = 64'h0000_2020_2020_2020;
         3'd6:    lim = 64'h0020_2020_2020_2020;
         3'd7:    lim = 64'h1F20_2020_2020_2020;
         default: lim = 64'h1F20_2020_2020_2020;
      endcase
      return lim;
   endfunction

   // Offset subtracted from a value that takes k extra bytes.
   function automatic logic [ValueWidth-1:0] base_of(input logic [2:0] k);
      logic [ValueWidth-1:0] b;
      case (k)
         3'd0:    b = 64'h0000_0000_0000_0000;
         3'd1:    b = 64'h0000_0000_0000_0020;
         3'd2:    b = 64'h0000_0000_0000_2020;
         3'd3:    b = 64'h0000_0000_0020_2020;
         3'd4:    b = 64'h0000_0000_2020_2020;
         3'd5:    b = 64'h0000_0020_2020_2020;
         3'd6:    b = 64'h0000_2020_2020_2020;
         3'd7:    b = 64'h0020_2020_2020_2020;
         default: b = 64'h0000_0000_0000_0000;
      endcase
      return b;
   endfunction

   // Number of extra bytes: the smallest k whose limit lies above the value.
   function automatic logic [LenWidth-1:0] extra_len(input logic [ValueWidth-1:0] v);
      logic [LenWidth-1:0] len;
      len = MaxExtra;
      for (int k = 7; k >= 0; k--) begin
         if (v < limit_of(3'(k))) begin
            len = LenWidth'(k);
         end
      end
      return len;
   endfunction

endpackage

FILE: hw/rtl/vioe_front.sv
// Front end: accepts a value, finds its length class and forms the head byte.
module vioe_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [vioe_pkg::ValueWidth-1:0]   req_value,
   output logic                              busy,
   input  vioe_pkg::vioe_fifo_status_type    fifo_status,
   output logic                              push,
   output vioe_pkg::vioe_entry_type          entry
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_REDUCE
   } state_type;

   state_type                       state_ff, state_in;
   logic [vioe_pkg::ValueWidth-1:0] value_ff, value_in;
   logic [vioe_pkg::LenWidth-1:0]   len_ff, len_in;
   logic [vioe_pkg::ValueWidth-1:0] rem_c;
   logic [vioe_pkg::ByteWidth-1:0]  head_c;
   logic                            escape_c;

   // Offset removal and head byte for the class held in the length register.
   always_comb begin
      escape_c = (len_ff == vioe_pkg::MaxExtra);
      if (escape_c) begin
         rem_c  = value_ff;
         head_c = vioe_pkg::EscapeByte;
      end else begin
         rem_c  = value_ff - vioe_pkg::base_of(len_ff[2:0]);
         head_c = {len_ff[2:0], rem_c[{len_ff[2:0], 3'b000} +: 5]};
      end
   end

   always_comb begin
      state_in = state_ff;
      value_in = value_ff;
      len_in   = len_ff;
      push     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               value_in = req_value;
               state_in = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            len_in   = vioe_pkg::extra_len(value_ff);
            state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            if (!fifo_status.full) begin
               push     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      value_ff <= value_in;
      len_ff   <= len_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign entry.rem  = rem_c;
   assign entry.len  = len_ff;
   assign entry.head = head_c;

endmodule

FILE: hw/rtl/vioe_fifo.sv
// Two-entry queue of classified items between front and back end.
`include "assert_macros.svh"

module vioe_fifo (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  vioe_pkg::vioe_entry_type       wr_entry,
   input  logic                           pop,
   output vioe_pkg::vioe_entry_type       rd_entry,
   output vioe_pkg::vioe_fifo_status_type status
);

   vioe_pkg::vioe_entry_type mem_ff [2];
   logic                     wr_ptr_ff, wr_ptr_in;
   logic                     rd_ptr_ff, rd_ptr_in;
   logic [vioe_pkg::FifoCountWidth-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_entry;
      end
   end

   assign rd_entry     = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == vioe_pkg::FifoDepth);
   assign status.empty = (count_ff == '0);

   `VIOE_ASSERT_ALWAYS(a_fifo_no_overflow, clock, reset, !(push && status.full))
   `VIOE_ASSERT_ALWAYS(a_fifo_no_underflow, clock, reset, !(pop && status.empty))
   `VIOE_ASSERT_IMPLIES(a_fifo_ptrs_match, clock, reset, status.empty || status.full, wr_ptr_ff == rd_ptr_ff)

endmodule

FILE: hw/rtl/vioe_back.sv
// Back end: emits the head byte and then the remainder bytes, one per cycle.
`include "assert_macros.svh"

module vioe_back (
   input  logic                             clock,
   input  logic                             reset,
   input  vioe_pkg::vioe_entry_type         entry,
   input  vioe_pkg::vioe_fifo_status_type   fifo_status,
   output logic                             pop,
   output logic                             rsp_valid,
   output logic [vioe_pkg::ByteWidth-1:0]   rsp_out_byte,
   output logic                             rsp_last
);

   logic [vioe_pkg::ValueWidth-1:0] rem_ff, rem_in;
   logic [vioe_pkg::LenWidth-1:0]   cnt_ff, cnt_in;
   logic                            valid_ff, valid_in;
   logic [vioe_pkg::ByteWidth-1:0]  byte_ff, byte_in;
   logic                            last_ff, last_in;
   logic [2:0]                      idx_c;

   always_comb begin
      idx_c    = 3'(cnt_ff - 4'd1);
      pop      = (cnt_ff == '0) && !fifo_status.empty;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      valid_in = 1'b0;
      byte_in  = byte_ff;
      last_in  = 1'b0;
      if (cnt_ff != '0) begin
         valid_in = 1'b1;
         byte_in  = rem_ff[{idx_c, 3'b000} +: 8];
         last_in  = (cnt_ff == 4'd1);
         cnt_in   = cnt_ff - 4'd1;
      end else if (pop) begin
         valid_in = 1'b1;
         byte_in  = entry.head;
         last_in  = (entry.len == '0);
         cnt_in   = entry.len;
         rem_in   = entry.rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
         last_ff  <= last_in;
      end
      rem_ff  <= rem_in;
      byte_ff <= byte_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_last     = last_ff;

   `VIOE_ASSERT_ALWAYS(a_back_cnt_range, clock, reset, cnt_ff <= vioe_pkg::MaxExtra)
   `VIOE_ASSERT_NEXT(a_back_cnt_emits, clock, reset, cnt_ff != '0, rsp_valid)
   `VIOE_ASSERT_IMPLIES(a_back_last_drained, clock, reset, rsp_valid && rsp_last, cnt_ff == '0)

endmodule

FILE: hw/rtl/varint_offset_encoder_u64.sv
// Top level of the prefix-length varint encoder for unsigned 64-bit items.
//
// Usage: an item is offered on req_value with start high and is taken at the
// rising clock edge where start is high and busy is low. Each item produces
// 1 to 9 encoded bytes on rsp_out_byte, most significant first, each shown for
// exactly one cycle with rsp_valid high; rsp_last marks the final byte.
// An item passes the value and length registers of the front end, the queue
// and the output register of the back end. The front end handles one item at
// a time (capture, length classification against the eight thresholds, offset
// subtraction), and busy stays high until the item is pushed. The back end
// emits one byte per cycle, the head byte and then the extra bytes of an item;
// a two-entry queue between them lets the front end classify ahead.
// When the queue is full the front end holds its item and keeps busy high.
// The receiver cannot stall: every byte must be taken as it appears.
// Reset is synchronous and active high; it empties the queue, drops any
// bytes in flight and returns the front end to idle. There is no configuration.
module varint_offset_encoder_u64 (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [vioe_pkg::ValueWidth-1:0] req_value,
   output logic                            rsp_valid,
   output logic [vioe_pkg::ByteWidth-1:0]  rsp_out_byte,
   output logic                            rsp_last
);

   vioe_pkg::vioe_entry_type       push_entry;
   vioe_pkg::vioe_entry_type       pop_entry;
   vioe_pkg::vioe_fifo_status_type fifo_status;
   logic                           push;
   logic                           pop;

   // The front end classifies one item at a time and forms its head byte.
   vioe_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_value   (req_value),
      .busy        (busy),
      .fifo_status (fifo_status),
      .push        (push),
      .entry       (push_entry)
   );

   // The queue decouples classification from byte emission.
   vioe_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .wr_entry (push_entry),
      .pop      (pop),
      .rd_entry (pop_entry),
      .status   (fifo_status)
   );

   // The back end streams out one byte per cycle from registered outputs.
   vioe_back u_back (
      .clock        (clock),
      .reset        (reset),
      .entry        (pop_entry),
      .fifo_status  (fifo_status),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule

FILE: test/varint_offset_encoder_u64_test.sv
// Self-checking testbench of the prefix-length varint encoder for 64-bit items.
`timescale 1ns / 100ps

module varint_offset_encoder_u64_test;

   // The clock period is 12 ns, split evenly between the high and low phases.
   localparam int HalfPeriod = 6;
   localparam int ResetCycles = 7;
   // An item yields nine bytes at most, and the tail below is watched after the
   // last owed byte has arrived, to catch any stray bytes.
   localparam int TailCycles = 12;
   // The slowest correct run offers 262 items of up to nine encoded bytes each.
   // The limit leaves a wide margin above that.
   localparam int CycleLimit = 200000;

   // One encoded byte as the encoder should emit it. The source value is kept
   // so that a mismatch can say which item the byte belongs to.
   typedef struct {
      logic [vioe_pkg::ByteWidth-1:0]  data;
      logic                            is_last;
      logic [vioe_pkg::ValueWidth-1:0] source;
   } encoded_byte_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            start = 1'b0;
   logic [vioe_pkg::ValueWidth-1:0] req_value = '0;
   logic                            busy;
   logic                            rsp_valid;
   logic [vioe_pkg::ByteWidth-1:0]  rsp_out_byte;
   logic                            rsp_last;

   // Bytes that the encoder owes us, oldest first.
   encoded_byte_type pending_bytes[$];
   int               mismatch_count = 0;
   int               cycle_count = 0;
   // When cleared, the sender offers each item without any idle cycles.
   bit               sender_gaps = 1'b1;

   varint_offset_encoder_u64 dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

   always begin
      #HalfPeriod clock = 1'b1;
      #HalfPeriod clock = 1'b0;
   end

   // Watchdog: a hung handshake or a lost byte must not stall the run forever.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("varint_offset_encoder_u64_test NOT OK");
         $finish;
      end
   end

   // Lowest value that takes k extra bytes: a 0x20 in each of the k low bytes.
   function automatic logic [vioe_pkg::ValueWidth-1:0] band_floor(input int k);
      logic [vioe_pkg::ValueWidth-1:0] floor_value;
      floor_value = '0;
      for (int i = 0; i < k; i++) begin
         floor_value = floor_value | (64'h20 << (8 * i));
      end
      return floor_value;
   endfunction

   // First value that no longer fits in k extra bytes. The seven-byte band
   // stops short at 0x1F in the top byte so that its head never reads as the
   // escape byte.
   function automatic logic [vioe_pkg::ValueWidth-1:0] band_ceiling(input int k);
      if (k == 7) begin
         return band_floor(7) | (64'h1F << 56);
      end
      return band_floor(k + 1);
   endfunction

   // Predicts the encoding of one value and queues its bytes, head first.
   function automatic void push_encoding(input logic [vioe_pkg::ValueWidth-1:0] value);
      int                              extra;
      logic [vioe_pkg::ValueWidth-1:0] remainder;
      encoded_byte_type                eb;
      // The smallest band whose ceiling lies above the value wins.
      extra = 8;
      for (int k = 7; k >= 0; k--) begin
         if (value < band_ceiling(k)) begin
            extra = k;
         end
      end
      eb.source = value;
      if (extra == 8) begin
         remainder = value;
         eb.data   = vioe_pkg::EscapeByte;
      end else begin
         remainder = value - band_floor(extra);
         eb.data   = 8'((extra << 5) | ((remainder >> (8 * extra)) & 64'h1F));
      end
      eb.is_last = (extra == 0);
      pending_bytes.push_back(eb);
      // The remaining bytes of the remainder follow, most significant first.
      for (int i = extra - 1; i >= 0; i--) begin
         eb.data    = 8'(remainder >> (8 * i));
         eb.is_last = (i == 0);
         pending_bytes.push_back(eb);
      end
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   // Offers one item and returns at the edge that accepts it. The task is
   // always entered at a rising edge, and start is left high on return, so a
   // following item with no gap keeps start high rather than toggling it
   // twice in one time step.
   task automatic send_item(input logic [vioe_pkg::ValueWidth-1:0] value);
      int gap;
      gap = sender_gaps ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start     <= 1'b1;
      req_value <= value;
      // Signals read straight after the edge still hold their values from
      // before it, which is what the encoder itself sampled.
      do @(posedge clock); while (busy !== 1'b0);
      push_encoding(value);
   endtask

   // Stops offering items until every byte owed so far has arrived. At least
   // one edge passes, so start is never lowered and raised in one time step.
   task automatic wait_for_drain();
      start <= 1'b0;
      do @(posedge clock); while (pending_bytes.size() != 0);
   endtask

   // Every byte on the result port is checked against the oldest one owed.
   // The receiver cannot hold results off, so each strobe is one byte taken.
   always @(posedge clock) begin
      encoded_byte_type expected;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %h (last %b)",
                                      rsp_out_byte, rsp_last));
         end else begin
            expected = pending_bytes.pop_front();
            if (rsp_out_byte !== expected.data) begin
               report_mismatch($sformatf("value %h: byte %h, expected %h",
                                         expected.source, rsp_out_byte, expected.data));
            end
            if (rsp_last !== expected.is_last) begin
               report_mismatch($sformatf("value %h: last %b, expected %b",
                                         expected.source, rsp_last, expected.is_last));
            end
         end
      end
   end

   // Both sides of every band boundary, plus the ends of the input range.
   // The top of the seven-byte band gives the largest non-escape head, and
   // its ceiling is the smallest value that takes the escape byte.
   task automatic test_band_edges();
      send_item('0);
      for (int k = 0; k < 8; k++) begin
         send_item(band_ceiling(k) - 64'd1);
         send_item(band_ceiling(k));
      end
      send_item('1);
   endtask

   // Alternating and single-bit patterns drive every bit of the value both ways.
   task automatic test_bit_patterns();
      send_item(64'h5555_5555_5555_5555);
      send_item(64'hAAAA_AAAA_AAAA_AAAA);
      send_item(64'h8000_0000_0000_0000);
      send_item(64'h7FFF_FFFF_FFFF_FFFF);
   endtask

   // Nine-byte encodings offered with no idle cycles at all, so that the
   // queue between classifier and byte emitter fills and busy holds items off.
   task automatic test_back_to_back_longest();
      sender_gaps = 1'b0;
      for (int i = 0; i < 10; i++) begin
         send_item({$urandom, $urandom} | 64'hE000_0000_0000_0000);
      end
      sender_gaps = 1'b1;
   endtask

   // Short bursts, each followed by a pause until the encoder has gone quiet,
   // so that items also arrive at an empty pipeline.
   task automatic test_drain_pause();
      for (int burst = 0; burst < 3; burst++) begin
         for (int i = 0; i < 5; i++) begin
            send_item({$urandom, $urandom} >> $urandom_range(0, 63));
         end
         wait_for_drain();
      end
   endtask

   // The bulk of the run. Most values are random words shifted right by a
   // random amount, which spreads them over all the encoding lengths;
   // some are full-width words and some sit just around a band boundary.
   // Every fifty items the sender picks afresh whether to idle at all.
   task automatic test_random_lengths();
      logic [vioe_pkg::ValueWidth-1:0] value;
      int                              pick;
      for (int i = 0; i < 215; i++) begin
         if (i % 50 == 0) begin
            sender_gaps = ($urandom_range(0, 3) != 0);
         end
         pick = $urandom_range(0, 9);
         if (pick <= 5) begin
            value = {$urandom, $urandom} >> $urandom_range(0, 63);
         end else if (pick <= 7) begin
            value = {$urandom, $urandom};
         end else begin
            value = band_ceiling($urandom_range(0, 7)) + $urandom_range(0, 7) - 64'd4;
         end
         send_item(value);
      end
      sender_gaps = 1'b1;
   endtask

   initial begin
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      test_band_edges();
      test_bit_patterns();
      test_back_to_back_longest();
      test_drain_pause();
      test_random_lengths();
      // Let every owed byte arrive, then watch a while longer for strays.
      wait_for_drain();
      repeat (TailCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("varint_offset_encoder_u64_test OK");
      end else begin
         $display("varint_offset_encoder_u64_test NOT OK");
      end
      $finish;
   end

endmodule
